[src/tsag_pkg.sv]
// ----------------------------------------------------------------------------
// tsag_pkg
// Shared types and constants of the three-state automaton grid: field
// widths, action and cell codes, sequencer states and neighbor offsets.
// ----------------------------------------------------------------------------
package tsag_pkg;

	// Field widths of the request and response channels
	localparam int ACT_W  = 2;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 5;
	localparam int CELL_W = 2;
	localparam int STEP_W = 4;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

	// Cell codes
	localparam logic [CELL_W-1:0] CELL_OFF    = 2'd0;
	localparam logic [CELL_W-1:0] CELL_FIRING = 2'd1;
	localparam logic [CELL_W-1:0] CELL_DYING  = 2'd2;
	localparam logic [CELL_W-1:0] CELL_BAD    = 2'd3;

	// Neighbor sweep: steps 0..8 issue reads of the 3x3 window, registered read
	// data arrives in the following step, step 9 writes the new cell.
	localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
	localparam logic [STEP_W-1:0] STEP_SELF  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_LAST  = 4'd9;
	localparam logic [STEP_W-1:0] FIRE_COUNT = 4'd2;

	// Offset codes within the window
	localparam logic [1:0] OFF_DEC  = 2'd0;
	localparam logic [1:0] OFF_SAME = 2'd1;
	localparam logic [1:0] OFF_INC  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_READ_WAIT,
		ST_GEN,
		ST_FINISH
	} state_t;

	// Row offset of a window step (step / 3)
	function automatic logic [1:0] nb_row_off(input logic [STEP_W-1:0] step);
		logic [1:0] off;
		case (step) inside
			4'd0, 4'd1, 4'd2: off = OFF_DEC;
			4'd3, 4'd4, 4'd5: off = OFF_SAME;
			default:          off = OFF_INC;
		endcase
		return off;
	endfunction

	// Column offset of a window step (step % 3)
	function automatic logic [1:0] nb_col_off(input logic [STEP_W-1:0] step);
		logic [1:0] off;
		case (step) inside
			4'd0, 4'd3, 4'd6: off = OFF_DEC;
			4'd1, 4'd4, 4'd7: off = OFF_SAME;
			default:          off = OFF_INC;
		endcase
		return off;
	endfunction

endpackage

[src/tsag_if.sv]
// ----------------------------------------------------------------------------
// tsag_req_if / tsag_rsp_if
// Valid/ready channels of the automaton grid: requests in, responses out.
// ----------------------------------------------------------------------------
interface tsag_req_if;
	logic                           valid;
	logic                           ready;
	logic [tsag_pkg::ACT_W-1:0]     action;
	logic [tsag_pkg::ROW_W-1:0]     row;
	logic [tsag_pkg::COL_W-1:0]     col;
	logic [tsag_pkg::CELL_W-1:0]    cell_in;

	modport source (output valid, action, row, col, cell_in, input ready);
	modport sink   (input valid, action, row, col, cell_in, output ready);
endinterface

interface tsag_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tsag_pkg::CELL_W-1:0]    cell_out;

	modport source (output valid, cell_out, input ready);
	modport sink   (input valid, cell_out, output ready);
endinterface

[src/tsag_bank.sv]
// ----------------------------------------------------------------------------
// tsag_bank
// One grid bank: cell memory with one write port and one registered read.
// ----------------------------------------------------------------------------
module tsag_bank #(
	parameter int ADDR_W = 10
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ADDR_W-1:0]            waddr,
	input  logic [tsag_pkg::CELL_W-1:0]  wdata,
	input  logic [ADDR_W-1:0]            raddr,
	output logic [tsag_pkg::CELL_W-1:0]  rdata
);

	logic [tsag_pkg::CELL_W-1:0] mem [2**ADDR_W];

	// Registered read; a read of the address being written returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/three_state_automaton_grid.sv]
// ----------------------------------------------------------------------------
// three_state_automaton_grid
// Toroidal grid of off/firing/dying cells; a request writes a cell, reads a
// cell or advances the whole grid one generation (three-state rule).
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    action, row, col, cell_in
//   rsp      out  valid/ready    cell_out
//
// One request at a time; req.ready is high only while the sequencer idles.
// A generation reads one window cell a cycle through the single read port
// of the grid memory, nine per cell plus one write step.
// After reset a clearing pass zeroes every address of both banks before
// the first request is taken.
// A stalled response is held in the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module three_state_automaton_grid #(
	parameter int GRID_SIDE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	tsag_req_if.sink    req,
	tsag_rsp_if.source  rsp
);

	localparam int IDX_W  = $clog2(GRID_SIDE);
	localparam int ADDR_W = 2 * IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIDE - 1);
	localparam logic [6:0]       SIDE_V   = 7'(GRID_SIDE);
	localparam logic [ADDR_W-1:0] CLR_LAST = '1;

	tsag_pkg::state_t state_q, state_d;

	// Latched request
	logic [tsag_pkg::ACT_W-1:0]  act_q;
	logic [IDX_W-1:0]            rw_q;
	logic [IDX_W-1:0]            cl_q;
	logic [tsag_pkg::CELL_W-1:0] val_q;
	logic                        in_q;

	// Generation sweep
	logic                         bank_q;
	logic [IDX_W-1:0]             r_q;
	logic [IDX_W-1:0]             c_q;
	logic [tsag_pkg::STEP_W-1:0]  k_q;
	logic [tsag_pkg::STEP_W-1:0]  cnt_q;
	logic [tsag_pkg::CELL_W-1:0]  self_q;

	logic [ADDR_W-1:0]            clr_q;
	logic [tsag_pkg::CELL_W-1:0]  res_q;

	// Response register
	logic                         rsp_valid_q;
	logic [tsag_pkg::CELL_W-1:0]  rsp_data_q;

	// Memory ports
	logic                         we0, we1;
	logic [ADDR_W-1:0]            waddr, raddr;
	logic [tsag_pkg::CELL_W-1:0]  wdata;
	logic [tsag_pkg::CELL_W-1:0]  rdata0, rdata1, rd_data;

	logic                         accept;
	logic                         req_inside;
	logic                         rsp_load;
	logic                         last_cell;
	logic [IDX_W-1:0]             nb_row, nb_col;
	logic [tsag_pkg::STEP_W-1:0]  cnt_final;
	logic [tsag_pkg::CELL_W-1:0]  next_cell;

	tsag_bank #(.ADDR_W(ADDR_W)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata0)
	);

	tsag_bank #(.ADDR_W(ADDR_W)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata1)
	);

	// Handshakes
	assign req.ready  = (state_q == tsag_pkg::ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign req_inside = ({2'b00, req.row} < SIDE_V) && ({2'b00, req.col} < SIDE_V);
	assign rsp_load   = (state_q == tsag_pkg::ST_FINISH) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid    = rsp_valid_q;
	assign rsp.cell_out = rsp_data_q;

	// Current grid lives in the bank picked by bank_q
	assign rd_data = bank_q ? rdata1 : rdata0;

	// Wrapped window coordinates for the current step
	always_comb begin
		case (tsag_pkg::nb_row_off(k_q))
			tsag_pkg::OFF_DEC:  nb_row = (r_q == '0) ? LAST_IDX : r_q - IDX_W'(1);
			tsag_pkg::OFF_SAME: nb_row = r_q;
			default:            nb_row = (r_q == LAST_IDX) ? '0 : r_q + IDX_W'(1);
		endcase
		case (tsag_pkg::nb_col_off(k_q))
			tsag_pkg::OFF_DEC:  nb_col = (c_q == '0) ? LAST_IDX : c_q - IDX_W'(1);
			tsag_pkg::OFF_SAME: nb_col = c_q;
			default:            nb_col = (c_q == LAST_IDX) ? '0 : c_q + IDX_W'(1);
		endcase
	end

	// Cell update from the finished count (last neighbor arrives at step 9)
	always_comb begin
		cnt_final = cnt_q + ((rd_data == tsag_pkg::CELL_FIRING) ?
			tsag_pkg::STEP_W'(1) : '0);
		if (self_q == tsag_pkg::CELL_FIRING) begin
			next_cell = tsag_pkg::CELL_DYING;
		end else if (self_q == tsag_pkg::CELL_DYING) begin
			next_cell = tsag_pkg::CELL_OFF;
		end else begin
			next_cell = (cnt_final == tsag_pkg::FIRE_COUNT) ?
				tsag_pkg::CELL_FIRING : tsag_pkg::CELL_OFF;
		end
	end

	assign last_cell = (r_q == LAST_IDX) && (c_q == LAST_IDX);

	// Memory port control
	always_comb begin
		we0   = 1'b0;
		we1   = 1'b0;
		waddr = {rw_q, cl_q};
		wdata = val_q;
		raddr = {nb_row, nb_col};
		unique case (state_q)
			tsag_pkg::ST_CLEAR: begin
				we0   = 1'b1;
				we1   = 1'b1;
				waddr = clr_q;
				wdata = tsag_pkg::CELL_OFF;
			end
			tsag_pkg::ST_WRITE: begin
				we0 = in_q && !bank_q;
				we1 = in_q && bank_q;
			end
			tsag_pkg::ST_READ: begin
				raddr = {rw_q, cl_q};
			end
			tsag_pkg::ST_GEN: begin
				if (k_q == tsag_pkg::STEP_LAST) begin
					we0   = bank_q;
					we1   = !bank_q;
					waddr = {r_q, c_q};
					wdata = next_cell;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsag_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = tsag_pkg::ST_IDLE;
			end
			tsag_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.action)
						tsag_pkg::ACT_WRITE: state_d = tsag_pkg::ST_WRITE;
						tsag_pkg::ACT_STEP:  state_d = tsag_pkg::ST_GEN;
						tsag_pkg::ACT_READ:  state_d = tsag_pkg::ST_READ;
						default:             state_d = tsag_pkg::ST_FINISH;
					endcase
				end
			end
			tsag_pkg::ST_WRITE:     state_d = tsag_pkg::ST_FINISH;
			tsag_pkg::ST_READ:      state_d = tsag_pkg::ST_READ_WAIT;
			tsag_pkg::ST_READ_WAIT: state_d = tsag_pkg::ST_FINISH;
			tsag_pkg::ST_GEN: begin
				if (k_q == tsag_pkg::STEP_LAST && last_cell) state_d = tsag_pkg::ST_FINISH;
			end
			tsag_pkg::ST_FINISH: begin
				if (rsp_load) state_d = tsag_pkg::ST_IDLE;
			end
			default: state_d = tsag_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsag_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: clearing counter, bank select, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			bank_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == tsag_pkg::ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == tsag_pkg::ST_GEN && k_q == tsag_pkg::STEP_LAST && last_cell) begin
				bank_q <= !bank_q;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request latch, sweep counters and result
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			rw_q  <= IDX_W'(req.row);
			cl_q  <= IDX_W'(req.col);
			val_q <= (req.cell_in == tsag_pkg::CELL_BAD) ? tsag_pkg::CELL_OFF : req.cell_in;
			in_q  <= req_inside;
			r_q   <= '0;
			c_q   <= '0;
			k_q   <= tsag_pkg::STEP_FIRST;
			res_q <= tsag_pkg::CELL_OFF;
		end
		if (state_q == tsag_pkg::ST_READ_WAIT && act_q == tsag_pkg::ACT_READ) begin
			res_q <= in_q ? rd_data : tsag_pkg::CELL_OFF;
		end
		if (state_q == tsag_pkg::ST_GEN) begin
			// Window accumulation: data of step k-1 is present at step k
			if (k_q == tsag_pkg::STEP_FIRST) begin
				cnt_q <= '0;
			end else if (k_q == tsag_pkg::STEP_SELF) begin
				self_q <= rd_data;
			end else if (k_q != tsag_pkg::STEP_LAST) begin
				cnt_q <= cnt_final;
			end
			// Step and cell advance
			if (k_q == tsag_pkg::STEP_LAST) begin
				k_q <= tsag_pkg::STEP_FIRST;
				if (c_q == LAST_IDX) begin
					c_q <= '0;
					r_q <= (r_q == LAST_IDX) ? '0 : r_q + IDX_W'(1);
				end else begin
					c_q <= c_q + IDX_W'(1);
				end
			end else begin
				k_q <= k_q + tsag_pkg::STEP_W'(1);
			end
		end
		if (rsp_load) rsp_data_q <= res_q;
	end

endmodule

[dv/three_state_automaton_grid_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_state_automaton_grid_tb
// Self-checking bench for the three-state automaton grid. A shadow copy of
// the grid predicts every response. Requests are directed corner and
// wrap-around cases, then random seeded patterns that are aged and read
// back, then mixed noise. Both channels stall at random.
// ----------------------------------------------------------------------------
module three_state_automaton_grid_tb;

	localparam int GRID_SIDE    = 32;
	localparam int CELL_COUNT   = GRID_SIDE * GRID_SIDE;
	// A whole generation passes with no handshake at all
	localparam int STALL_LIMIT  = 40000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [tsag_pkg::CELL_W-1:0] cell_val;
		logic [tsag_pkg::ACT_W-1:0]  action;
		logic [tsag_pkg::ROW_W-1:0]  row;
		logic [tsag_pkg::COL_W-1:0]  col;
	} cell_expect_t;

	logic clk;
	logic arst_n;

	tsag_req_if req_ch ();
	tsag_rsp_if rsp_ch ();

	// Shadow grid, row-major
	logic [tsag_pkg::CELL_W-1:0] life_grid [CELL_COUNT];
	cell_expect_t      expected_cells [$];
	int                failures;
	int                stall_cycles;
	bit                no_gaps;

	three_state_automaton_grid #(
		.GRID_SIDE(GRID_SIDE)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random gap decision shared by both channels
	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(0, 99) < 38);
	endfunction

	// One generation of the shadow grid; all cells update from the old one
	function automatic void age_grid();
		logic [tsag_pkg::CELL_W-1:0] nxt [CELL_COUNT];
		int firing;
		int nr;
		int nc;
		for (int r = 0; r < GRID_SIDE; r++) begin
			for (int c = 0; c < GRID_SIDE; c++) begin
				firing = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						nr = (r + dr + GRID_SIDE) % GRID_SIDE;
						nc = (c + dc + GRID_SIDE) % GRID_SIDE;
						if ((dr != 0 || dc != 0) &&
							life_grid[nr * GRID_SIDE + nc] == tsag_pkg::CELL_FIRING)
							firing++;
					end
				end
				case (life_grid[r * GRID_SIDE + c])
					tsag_pkg::CELL_FIRING: nxt[r * GRID_SIDE + c] = tsag_pkg::CELL_DYING;
					tsag_pkg::CELL_DYING:  nxt[r * GRID_SIDE + c] = tsag_pkg::CELL_OFF;
					default: nxt[r * GRID_SIDE + c] = (firing == tsag_pkg::FIRE_COUNT) ?
						tsag_pkg::CELL_FIRING : tsag_pkg::CELL_OFF;
				endcase
			end
		end
		for (int i = 0; i < CELL_COUNT; i++)
			life_grid[i] = nxt[i];
	endfunction

	// Apply one request to the shadow grid and return the expected cell_out
	function automatic logic [tsag_pkg::CELL_W-1:0] predict_cell_out(
		input logic [tsag_pkg::ACT_W-1:0]  act,
		input logic [tsag_pkg::ROW_W-1:0]  row,
		input logic [tsag_pkg::COL_W-1:0]  col,
		input logic [tsag_pkg::CELL_W-1:0] cell_val
	);
		logic [tsag_pkg::CELL_W-1:0] out_val;
		bit                on_grid;
		int                idx;
		out_val = tsag_pkg::CELL_OFF;
		on_grid = (int'(row) < GRID_SIDE) && (int'(col) < GRID_SIDE);
		idx     = int'(row) * GRID_SIDE + int'(col);
		case (act)
			tsag_pkg::ACT_WRITE: begin
				// code 3 lands as off
				if (on_grid)
					life_grid[idx] = (cell_val == tsag_pkg::CELL_BAD) ?
						tsag_pkg::CELL_OFF : cell_val;
			end
			tsag_pkg::ACT_STEP: begin
				age_grid();
			end
			tsag_pkg::ACT_READ: begin
				if (on_grid)
					out_val = life_grid[idx];
			end
			default: begin
				// unused action: no effect, response is zero
			end
		endcase
		return out_val;
	endfunction

	// Drive one request, wait for acceptance, then record its expected response
	task automatic send_request(
		input logic [tsag_pkg::ACT_W-1:0]  act,
		input logic [tsag_pkg::ROW_W-1:0]  row,
		input logic [tsag_pkg::COL_W-1:0]  col,
		input logic [tsag_pkg::CELL_W-1:0] cell_val
	);
		cell_expect_t entry;
		@(negedge clk);
		while (take_gap()) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.action  <= act;
		req_ch.row     <= row;
		req_ch.col     <= col;
		req_ch.cell_in <= cell_val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		entry.cell_val = predict_cell_out(act, row, col, cell_val);
		entry.action   = act;
		entry.row      = row;
		entry.col      = col;
		expected_cells.push_back(entry);
	endtask

	// Response stalls
	always @(negedge clk) begin
		rsp_ch.ready <= !take_gap();
	end

	// Response check and stall counter
	always @(posedge clk) begin
		cell_expect_t want;
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_cells.size() == 0) begin
				$display("%0t: response with no request pending: expected none, actual cell_out %0d",
					$time, rsp_ch.cell_out);
				failures++;
			end else begin
				want = expected_cells.pop_front();
				if (rsp_ch.cell_out !== want.cell_val) begin
					$display("%0t: cell_out mismatch (action %0d row %0d col %0d): expected %0d, actual %0d",
						$time, want.action, want.row, want.col, want.cell_val, rsp_ch.cell_out);
					failures++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Grid after reset, corner writes, code 3 write, unused action
	task automatic test_edges_and_codes();
		send_request(tsag_pkg::ACT_READ, 5'd0, 5'd0, tsag_pkg::CELL_BAD);
		send_request(tsag_pkg::ACT_READ, 5'd31, 5'd31, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_WRITE, 5'd0, 5'd0, tsag_pkg::CELL_FIRING);
		send_request(tsag_pkg::ACT_WRITE, 5'd31, 5'd31, tsag_pkg::CELL_DYING);
		send_request(tsag_pkg::ACT_WRITE, 5'd17, 5'd9, tsag_pkg::CELL_FIRING);
		send_request(tsag_pkg::ACT_WRITE, 5'd17, 5'd9, tsag_pkg::CELL_BAD);
		send_request(tsag_pkg::ACT_READ, 5'd17, 5'd9, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_NONE, 5'd31, 5'd31, tsag_pkg::CELL_BAD);
		send_request(tsag_pkg::ACT_READ, 5'd31, 5'd31, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_READ, 5'd0, 5'd0, tsag_pkg::CELL_OFF);
	endtask

	// Births across the wrap, three neighbors giving no birth, aging chain
	task automatic test_wrap_and_counts();
		// opposite corners firing: (0,31) and (31,0) see exactly two across the wrap
		send_request(tsag_pkg::ACT_WRITE, 5'd31, 5'd31, tsag_pkg::CELL_FIRING);
		// row of three: the cell above the middle sees three, its neighbor sees two
		send_request(tsag_pkg::ACT_WRITE, 5'd10, 5'd10, tsag_pkg::CELL_FIRING);
		send_request(tsag_pkg::ACT_WRITE, 5'd10, 5'd11, tsag_pkg::CELL_FIRING);
		send_request(tsag_pkg::ACT_WRITE, 5'd10, 5'd12, tsag_pkg::CELL_FIRING);
		send_request(tsag_pkg::ACT_STEP, 5'd31, 5'd0, tsag_pkg::CELL_BAD);
		send_request(tsag_pkg::ACT_READ, 5'd0, 5'd31, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_READ, 5'd31, 5'd0, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_READ, 5'd0, 5'd0, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_READ, 5'd9, 5'd11, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_READ, 5'd9, 5'd10, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_STEP, 5'd0, 5'd31, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_READ, 5'd0, 5'd0, tsag_pkg::CELL_OFF);
		send_request(tsag_pkg::ACT_READ, 5'd0, 5'd31, tsag_pkg::CELL_OFF);
	endtask

	// Seed a small window (may wrap), age it once or twice, read it back
	task automatic run_pattern_burst();
		int unsigned r0;
		int unsigned c0;
		int unsigned span;
		int unsigned pick;
		logic [tsag_pkg::CELL_W-1:0] cell_val;
		r0   = $urandom_range(0, GRID_SIDE - 1);
		c0   = $urandom_range(0, GRID_SIDE - 1);
		span = $urandom_range(3, 6);
		repeat ($urandom_range(6, 12)) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				cell_val = tsag_pkg::CELL_FIRING;
			else if (pick < 75)
				cell_val = tsag_pkg::CELL_DYING;
			else if (pick < 90)
				cell_val = tsag_pkg::CELL_OFF;
			else
				cell_val = tsag_pkg::CELL_BAD;
			send_request(tsag_pkg::ACT_WRITE,
				tsag_pkg::ROW_W'((r0 + $urandom_range(0, span - 1)) % GRID_SIDE),
				tsag_pkg::COL_W'((c0 + $urandom_range(0, span - 1)) % GRID_SIDE), cell_val);
		end
		repeat ($urandom_range(1, 2)) begin
			send_request(tsag_pkg::ACT_STEP, tsag_pkg::ROW_W'($urandom),
				tsag_pkg::COL_W'($urandom), tsag_pkg::CELL_W'($urandom));
			// read the window and its one-cell border
			repeat ($urandom_range(4, 6)) begin
				send_request(tsag_pkg::ACT_READ,
					tsag_pkg::ROW_W'((r0 + GRID_SIDE - 1 + $urandom_range(0, span + 1))
						% GRID_SIDE),
					tsag_pkg::COL_W'((c0 + GRID_SIDE - 1 + $urandom_range(0, span + 1))
						% GRID_SIDE),
					tsag_pkg::CELL_W'($urandom));
			end
		end
	endtask

	task automatic test_pattern_bursts();
		repeat (16)
			run_pattern_burst();
	endtask

	// Same bursts with both channels never stalling
	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (2)
			run_pattern_burst();
		no_gaps = 1'b0;
	endtask

	// Random requests of every kind; generations kept rare
	task automatic test_mixed_noise();
		logic [tsag_pkg::ACT_W-1:0] act;
		repeat (60) begin
			case ($urandom_range(0, 19))
				0:          act = tsag_pkg::ACT_STEP;
				1, 2, 3:    act = tsag_pkg::ACT_NONE;
				4, 5, 6, 7,
				8, 9, 10:   act = tsag_pkg::ACT_WRITE;
				default:    act = tsag_pkg::ACT_READ;
			endcase
			send_request(act, tsag_pkg::ROW_W'($urandom), tsag_pkg::COL_W'($urandom),
				tsag_pkg::CELL_W'($urandom));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.action  = tsag_pkg::ACT_NONE;
		req_ch.row     = '0;
		req_ch.col     = '0;
		req_ch.cell_in = tsag_pkg::CELL_OFF;
		rsp_ch.ready   = 1'b0;
		no_gaps        = 1'b0;
		failures       = 0;
		for (int i = 0; i < CELL_COUNT; i++)
			life_grid[i] = tsag_pkg::CELL_OFF;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_edges_and_codes();
		test_wrap_and_counts();
		test_pattern_bursts();
		test_back_to_back();
		test_mixed_noise();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
src/tsag_pkg.sv
src/tsag_if.sv
src/tsag_bank.sv
src/three_state_automaton_grid.sv
dv/three_state_automaton_grid_tb.sv
